// ----- rtl/json_byte_tokenizer_assert.svh -----
// Assertion macros for the JSON byte tokenizer
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define JBT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");
`define JBT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define JBT_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define JBT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/jbt_pkg.sv -----
// Types, codes and character constants for the JSON byte tokenizer
package jbt_pkg;

  localparam logic [3:0] TK_DICT_OPEN  = 4'd0;
  localparam logic [3:0] TK_DICT_CLOSE = 4'd1;
  localparam logic [3:0] TK_ARR_OPEN   = 4'd2;
  localparam logic [3:0] TK_ARR_CLOSE  = 4'd3;
  localparam logic [3:0] TK_COLON      = 4'd4;
  localparam logic [3:0] TK_COMMA      = 4'd5;
  localparam logic [3:0] TK_FALSE      = 4'd6;
  localparam logic [3:0] TK_STR_BEGIN  = 4'd9;
  localparam logic [3:0] TK_STR_BYTE   = 4'd10;
  localparam logic [3:0] TK_STR_END    = 4'd11;
  localparam logic [3:0] TK_NUM_BYTE   = 4'd12;
  localparam logic [3:0] TK_NUM_END    = 4'd13;
  localparam logic [3:0] TK_ERROR      = 4'd14;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_LITERAL    = 3'd2;
  localparam logic [2:0] ERR_UNICODE    = 3'd3;
  localparam logic [2:0] ERR_UNTERM     = 3'd4;

  localparam logic [1:0] LIT_FALSE = 2'd0;
  localparam logic [1:0] LIT_TRUE  = 2'd1;
  localparam logic [1:0] LIT_NULL  = 2'd2;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0a;
  localparam logic [7:0] CH_CR     = 8'h0d;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0c;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_E   = 8'h45;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_E      = 8'h65;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_L      = 8'h6c;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_S      = 8'h73;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam int unsigned MAX_TOKENS = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } text_item_t;

  typedef struct packed {
    logic [3:0] token_kind;
    logic [7:0] data_byte;
    logic [2:0] error_code;
    logic       last_result;
  } token_t;

  typedef struct packed {
    logic [1:0]                  count;
    token_t [MAX_TOKENS-1:0]     slot;
  } lex_result_t;

  function automatic token_t make_token(logic [3:0] kind, logic [7:0] data,
                                        logic [2:0] code);
    token_t t;
    t.token_kind  = kind;
    t.data_byte   = data;
    t.error_code  = code;
    t.last_result = 1'b0;
    return t;
  endfunction

  function automatic logic is_num_start(logic [7:0] b);
    return (b == CH_MINUS) || ((b >= CH_ZERO) && (b <= CH_NINE));
  endfunction

  function automatic logic is_num_char(logic [7:0] b);
    return is_num_start(b) || (b == CH_PLUS) || (b == CH_E) || (b == CH_UP_E) ||
           (b == CH_DOT);
  endfunction

  function automatic logic [7:0] unescape(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b == CH_B) r = CH_BS;
    else if (b == CH_F) r = CH_FF;
    else if (b == CH_N) r = CH_LF;
    else if (b == CH_R) r = CH_CR;
    else if (b == CH_T) r = CH_TAB;
    return r;
  endfunction

  function automatic logic [2:0] lit_len(logic [1:0] w);
    return (w == LIT_FALSE) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] lit_char(logic [1:0] w, logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    unique case (w)
      LIT_FALSE: begin
        unique case (pos)
          3'd0: c = CH_F;
          3'd1: c = CH_A;
          3'd2: c = CH_L;
          3'd3: c = CH_S;
          3'd4: c = CH_E;
          default: c = 8'h00;
        endcase
      end
      LIT_TRUE: begin
        unique case (pos)
          3'd0: c = CH_T;
          3'd1: c = CH_R;
          3'd2: c = CH_U;
          3'd3: c = CH_E;
          default: c = 8'h00;
        endcase
      end
      default: begin
        unique case (pos)
          3'd0: c = CH_N;
          3'd1: c = CH_U;
          3'd2: c = CH_L;
          3'd3: c = CH_L;
          default: c = 8'h00;
        endcase
      end
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/jbt_chan.sv -----
// Valid/ready channel carrying one payload item
interface jbt_chan #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/jbt_lexer.sv -----
// Lexer state and single-pass decode of one byte into up to three tokens
module jbt_lexer import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  text_item_t  item,
  output lex_result_t result
);

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_STR  = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_NUM  = 3'd3,
    MODE_LIT  = 3'd4,
    MODE_ERR  = 3'd5
  } mode_t;

  mode_t       mode, mode_next;
  logic [1:0]  which, which_next;
  logic [2:0]  pos, pos_next;
  logic [1:0]  n;
  logic        go_idle;
  logic [7:0]  b;
  logic [1:0]  lit_w;
  logic [2:0]  pos_inc;
  token_t [MAX_TOKENS-1:0] slots;

  assign b       = item.in_byte;
  assign lit_w   = (which == 2'd3) ? LIT_NULL : which;
  assign pos_inc = pos + 3'd1;

  always_comb begin
    mode_next  = mode;
    which_next = which;
    pos_next   = pos;
    n          = 2'd0;
    slots      = '0;
    go_idle    = 1'b0;

    unique case (mode)
      MODE_IDLE: go_idle = 1'b1;
      MODE_NUM: begin
        if (is_num_char(b)) begin
          slots[n] = make_token(TK_NUM_BYTE, b, ERR_NONE);
          n = n + 2'd1;
        end else begin
          slots[n] = make_token(TK_NUM_END, 8'h00, ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
          go_idle = 1'b1;
        end
      end
      MODE_STR: begin
        if (b == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else if (b == CH_QUOTE) begin
          slots[n] = make_token(TK_STR_END, 8'h00, ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          slots[n] = make_token(TK_STR_BYTE, b, ERR_NONE);
          n = n + 2'd1;
        end
      end
      MODE_ESC: begin
        if (b == CH_U) begin
          slots[n] = make_token(TK_ERROR, 8'h00, ERR_UNICODE);
          n = n + 2'd1;
          mode_next = MODE_ERR;
          pos_next = 3'd0;
        end else begin
          slots[n] = make_token(TK_STR_BYTE, unescape(b), ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_STR;
        end
      end
      MODE_LIT: begin
        if ((pos < lit_len(lit_w)) && (b == lit_char(lit_w, pos))) begin
          pos_next = pos_inc;
          if (pos_inc == lit_len(lit_w)) begin
            slots[n] = make_token(TK_FALSE + {2'b00, lit_w}, 8'h00, ERR_NONE);
            n = n + 2'd1;
            mode_next = MODE_IDLE;
            pos_next = 3'd0;
          end
        end else begin
          slots[n] = make_token(TK_ERROR, 8'h00, ERR_LITERAL);
          n = n + 2'd1;
          mode_next = MODE_ERR;
          pos_next = 3'd0;
        end
      end
      default: ;
    endcase

    if (go_idle) begin
      unique case (b)
        CH_LBRACE: begin slots[n] = make_token(TK_DICT_OPEN, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_RBRACE: begin slots[n] = make_token(TK_DICT_CLOSE, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_LBRACK: begin slots[n] = make_token(TK_ARR_OPEN, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_RBRACK: begin slots[n] = make_token(TK_ARR_CLOSE, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_COLON: begin slots[n] = make_token(TK_COLON, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_COMMA: begin slots[n] = make_token(TK_COMMA, 8'h00, ERR_NONE);
          n = n + 2'd1; end
        CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
        CH_F: begin which_next = LIT_FALSE; pos_next = 3'd1; mode_next = MODE_LIT; end
        CH_T: begin which_next = LIT_TRUE; pos_next = 3'd1; mode_next = MODE_LIT; end
        CH_N: begin which_next = LIT_NULL; pos_next = 3'd1; mode_next = MODE_LIT; end
        CH_QUOTE: begin
          slots[n] = make_token(TK_STR_BEGIN, 8'h00, ERR_NONE);
          n = n + 2'd1;
          mode_next = MODE_STR;
        end
        default: begin
          if (is_num_start(b)) begin
            slots[n] = make_token(TK_NUM_BYTE, b, ERR_NONE);
            n = n + 2'd1;
            mode_next = MODE_NUM;
          end else begin
            slots[n] = make_token(TK_ERROR, 8'h00, ERR_UNEXPECTED);
            n = n + 2'd1;
            mode_next = MODE_ERR;
            pos_next = 3'd0;
          end
        end
      endcase
    end

    if (item.end_of_message) begin
      if ((mode_next == MODE_STR) || (mode_next == MODE_ESC) ||
          (mode_next == MODE_LIT)) begin
        slots[n] = make_token(TK_ERROR, 8'h00, ERR_UNTERM);
        n = n + 2'd1;
      end else if (mode_next == MODE_NUM) begin
        slots[n] = make_token(TK_NUM_END, 8'h00, ERR_NONE);
        n = n + 2'd1;
      end
      mode_next  = MODE_IDLE;
      which_next = LIT_FALSE;
      pos_next   = 3'd0;
    end

    if (n != 2'd0) begin
      slots[n - 2'd1].last_result = 1'b1;
    end
  end

  assign result.count = n;
  assign result.slot  = slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= MODE_IDLE;
      which <= LIT_FALSE;
      pos   <= 3'd0;
    end else if (accept) begin
      mode  <= mode_next;
      which <= which_next;
      pos   <= pos_next;
    end
  end

endmodule

// ----- rtl/jbt_out_buf.sv -----
// Result register that holds a byte's tokens and hands them out one per cycle while the receiver is ready
module jbt_out_buf import jbt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  lex_result_t result,
  output logic        can_load,
  jbt_chan.source     tokens
);

  logic [1:0]              cnt;
  token_t [MAX_TOKENS-1:0] slot;
  logic                    pop;

  assign pop            = tokens.valid && tokens.ready;
  assign tokens.valid   = (cnt != 2'd0);
  assign tokens.payload = slot[0];
  assign can_load       = (cnt == 2'd0) || ((cnt == 2'd1) && tokens.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (load) begin
      cnt <= result.count;
    end else if (pop) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= result.slot;
    end else if (pop) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

// ----- rtl/json_byte_tokenizer.sv -----
// The first token of a byte appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while the receiver is ready and each byte gives at
// most one token; a byte giving more holds the input while the result register
// drains one token per ready cycle. Bytes giving no token pass at one per cycle.
// Reset (rst, synchronous): lexer returns to idle between tokens, tokens drop.
`include "json_byte_tokenizer_assert.svh"

module json_byte_tokenizer import jbt_pkg::*; (
  input logic     clk,
  input logic     rst,
  jbt_chan.sink   text,
  jbt_chan.source tokens
);

  lex_result_t result;
  logic        accept;
  logic        can_load;

  assign text.ready = can_load;
  assign accept     = text.valid && text.ready;

  jbt_lexer u_lexer (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (text.payload),
    .result (result)
  );

  jbt_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .result   (result),
    .can_load (can_load),
    .tokens   (tokens)
  );

  `JBT_ASSERT_NEXT(a_more_follow, clk, rst,
    tokens.valid && tokens.ready && !tokens.payload.last_result, tokens.valid)
  `JBT_ASSERT_IMPLY(a_accept_drained, clk, rst, accept,
    !tokens.valid || (tokens.ready && tokens.payload.last_result))
  `JBT_ASSERT_IMPLY(a_error_code, clk, rst, tokens.valid,
    (tokens.payload.token_kind == TK_ERROR) == (tokens.payload.error_code != ERR_NONE))

endmodule

// ----- sim/json_byte_tokenizer_test.sv -----
// Self-checking testbench for the JSON byte tokenizer: directed and random byte streams.
`timescale 1ns / 1ps

module json_byte_tokenizer_test;
  import jbt_pkg::*;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_STR, SCAN_ESC, SCAN_NUM, SCAN_LIT, SCAN_ERR
  } scan_mode_t;

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int ITEMS_PER_PHASE = 78;

  logic clk = 1'b0;
  logic rst = 1'b1;

  jbt_chan #(.payload_t(text_item_t)) text_if ();
  jbt_chan #(.payload_t(token_t)) token_if ();

  json_byte_tokenizer uut (
    .clk    (clk),
    .rst    (rst),
    .text   (text_if.sink),
    .tokens (token_if.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t pending_bytes[$];
  token_t     expected_tokens[$];
  token_t     byte_tokens[$];
  int         bytes_in_flight = 0;
  int         bytes_sent = 0;
  int         mismatches = 0;
  int         idle_cycles = 0;
  int         sender_idle_pct = 0;
  int         receiver_stall_pct = 0;

  scan_mode_t scan_mode = SCAN_IDLE;
  logic [1:0] lit_sel = LIT_FALSE;
  logic [2:0] lit_pos = 3'd0;

  string      lit_word [3] = '{"false", "true", "null"};
  logic [7:0] structural_chars [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                       CH_COLON, CH_COMMA};
  logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
  logic [7:0] escape_chars [8] = '{CH_B, CH_F, CH_N, CH_R, CH_T, CH_QUOTE, CH_BSLASH,
                                   CH_SLASH};

  function automatic void add_token(logic [3:0] kind, logic [7:0] data, logic [2:0] code);
    token_t t;
    t.token_kind  = kind;
    t.data_byte   = data;
    t.error_code  = code;
    t.last_result = 1'b0;
    byte_tokens.push_back(t);
  endfunction

  function automatic void lex_error(logic [2:0] code);
    add_token(TK_ERROR, 8'h00, code);
    scan_mode = SCAN_ERR;
    lit_pos = 3'd0;
  endfunction

  function automatic logic num_lead(logic [7:0] b);
    return b == CH_MINUS || (b >= CH_ZERO && b <= CH_NINE);
  endfunction

  function automatic logic num_char(logic [7:0] b);
    return num_lead(b) || b == CH_PLUS || b == CH_E || b == CH_UP_E || b == CH_DOT;
  endfunction

  function automatic void between_tokens(logic [7:0] b);
    case (b)
      CH_LBRACE: add_token(TK_DICT_OPEN, 8'h00, ERR_NONE);
      CH_RBRACE: add_token(TK_DICT_CLOSE, 8'h00, ERR_NONE);
      CH_LBRACK: add_token(TK_ARR_OPEN, 8'h00, ERR_NONE);
      CH_RBRACK: add_token(TK_ARR_CLOSE, 8'h00, ERR_NONE);
      CH_COLON: add_token(TK_COLON, 8'h00, ERR_NONE);
      CH_COMMA: add_token(TK_COMMA, 8'h00, ERR_NONE);
      CH_SPACE, CH_TAB, CH_LF, CH_CR: ;
      CH_F, CH_T, CH_N: begin
        lit_sel = (b == CH_F) ? LIT_FALSE : ((b == CH_T) ? LIT_TRUE : LIT_NULL);
        lit_pos = 3'd1;
        scan_mode = SCAN_LIT;
      end
      CH_QUOTE: begin
        add_token(TK_STR_BEGIN, 8'h00, ERR_NONE);
        scan_mode = SCAN_STR;
      end
      default: begin
        if (num_lead(b)) begin
          add_token(TK_NUM_BYTE, b, ERR_NONE);
          scan_mode = SCAN_NUM;
        end else begin
          lex_error(ERR_UNEXPECTED);
        end
      end
    endcase
  endfunction

  function automatic void lex_byte(logic [7:0] b, logic eom);
    logic [7:0] c;
    string word;
    byte_tokens.delete();
    case (scan_mode)
      SCAN_NUM: begin
        if (num_char(b)) begin
          add_token(TK_NUM_BYTE, b, ERR_NONE);
        end else begin
          add_token(TK_NUM_END, 8'h00, ERR_NONE);
          scan_mode = SCAN_IDLE;
          between_tokens(b);
        end
      end
      SCAN_IDLE: between_tokens(b);
      SCAN_STR: begin
        if (b == CH_BSLASH) begin
          scan_mode = SCAN_ESC;
        end else if (b == CH_QUOTE) begin
          add_token(TK_STR_END, 8'h00, ERR_NONE);
          scan_mode = SCAN_IDLE;
        end else begin
          add_token(TK_STR_BYTE, b, ERR_NONE);
        end
      end
      SCAN_ESC: begin
        if (b == CH_U) begin
          lex_error(ERR_UNICODE);
        end else begin
          case (b)
            CH_B: c = CH_BS;
            CH_F: c = CH_FF;
            CH_N: c = CH_LF;
            CH_R: c = CH_CR;
            CH_T: c = CH_TAB;
            default: c = b;
          endcase
          add_token(TK_STR_BYTE, c, ERR_NONE);
          scan_mode = SCAN_STR;
        end
      end
      SCAN_LIT: begin
        word = lit_word[(lit_sel == 2'd3) ? LIT_NULL : lit_sel];
        if (lit_pos < word.len() && b == word[lit_pos]) begin
          lit_pos = lit_pos + 3'd1;
          if (lit_pos == word.len()) begin
            add_token(TK_FALSE + {2'b00, lit_sel}, 8'h00, ERR_NONE);
            scan_mode = SCAN_IDLE;
            lit_pos = 3'd0;
          end
        end else begin
          lex_error(ERR_LITERAL);
        end
      end
      default: ;
    endcase
    if (eom) begin
      if (scan_mode inside {SCAN_STR, SCAN_ESC, SCAN_LIT})
        add_token(TK_ERROR, 8'h00, ERR_UNTERM);
      else if (scan_mode == SCAN_NUM)
        add_token(TK_NUM_END, 8'h00, ERR_NONE);
      scan_mode = SCAN_IDLE;
      lit_sel = LIT_FALSE;
      lit_pos = 3'd0;
    end
    if (byte_tokens.size() != 0)
      byte_tokens[byte_tokens.size() - 1].last_result = 1'b1;
    foreach (byte_tokens[i])
      expected_tokens.push_back(byte_tokens[i]);
  endfunction

  function automatic byte_q_t text_bytes(string s);
    byte_q_t q;
    for (int i = 0; i < s.len(); i++)
      q.push_back(s[i]);
    return q;
  endfunction

  task automatic send_bytes(byte_q_t msg);
    text_item_t item;
    foreach (msg[i]) begin
      item.in_byte = msg[i];
      item.end_of_message = (i == msg.size() - 1);
      bytes_in_flight++;
      bytes_sent++;
      pending_bytes.push_back(item);
    end
  endtask

  task automatic random_message();
    byte_q_t msg;
    string word;
    int ntok;
    int len;
    int pick;
    logic [7:0] c;
    msg = {};
    if ($urandom_range(99) < 8) begin
      len = $urandom_range(1, 6);
      repeat (len) msg.push_back(8'($urandom));
    end else begin
      ntok = $urandom_range(1, 8);
      repeat (ntok) begin
        case ($urandom_range(5))
          0: msg.push_back(structural_chars[$urandom_range(5)]);
          1: msg.push_back(blank_chars[$urandom_range(3)]);
          2: begin
            word = lit_word[$urandom_range(2)];
            for (int i = 0; i < word.len(); i++) msg.push_back(word[i]);
          end
          3: begin
            msg.push_back(CH_QUOTE);
            len = $urandom_range(0, 5);
            repeat (len) begin
              pick = $urandom_range(19);
              if (pick < 3) begin
                msg.push_back(CH_BSLASH);
                msg.push_back(escape_chars[$urandom_range(7)]);
              end else if (pick == 3) begin
                msg.push_back(CH_BSLASH);
                msg.push_back(($urandom_range(3) == 0) ? CH_U : 8'($urandom));
              end else begin
                do c = (pick < 7) ? 8'($urandom) : 8'($urandom_range(8'h20, 8'h7e));
                while (c == CH_QUOTE || c == CH_BSLASH);
                msg.push_back(c);
              end
            end
            msg.push_back(CH_QUOTE);
          end
          default: begin
            if ($urandom_range(1)) msg.push_back(CH_MINUS);
            len = $urandom_range(1, 3);
            repeat (len) msg.push_back(8'(CH_ZERO + $urandom_range(9)));
            if ($urandom_range(3) == 0) begin
              msg.push_back(CH_DOT);
              msg.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
            if ($urandom_range(3) == 0) begin
              msg.push_back($urandom_range(1) ? CH_E : CH_UP_E);
              msg.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
              msg.push_back(8'(CH_ZERO + $urandom_range(9)));
            end
          end
        endcase
        if ($urandom_range(3) == 0) msg.push_back($urandom_range(1) ? CH_COMMA : CH_SPACE);
      end
      pick = $urandom_range(99);
      if (pick < 10)
        msg.insert($urandom_range(msg.size() - 1), 8'($urandom));
      else if (pick < 20 && msg.size() > 1)
        msg = msg[0:$urandom_range(msg.size() - 2)];
    end
    send_bytes(msg);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      text_if.valid <= 1'b0;
      text_if.payload <= '0;
    end else begin
      if (text_if.valid && text_if.ready) begin
        lex_byte(text_if.payload.in_byte, text_if.payload.end_of_message);
        bytes_in_flight--;
      end
      if (!text_if.valid || text_if.ready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          text_if.payload <= pending_bytes.pop_front();
          text_if.valid <= 1'b1;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    token_t want;
    if (rst) begin
      token_if.ready <= 1'b0;
    end else begin
      if (token_if.valid && token_if.ready) begin
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token: kind %0d data %02h code %0d last %0d",
                     token_if.payload.token_kind, token_if.payload.data_byte,
                     token_if.payload.error_code, token_if.payload.last_result);
        end else begin
          want = expected_tokens.pop_front();
          if (token_if.payload.token_kind !== want.token_kind ||
              token_if.payload.data_byte !== want.data_byte ||
              token_if.payload.error_code !== want.error_code ||
              token_if.payload.last_result !== want.last_result) begin
            mismatches++;
            if (mismatches <= 10)
              $display("token mismatch: expected kind %0d data %02h code %0d last %0d, %s",
                       want.token_kind, want.data_byte, want.error_code, want.last_result,
                       $sformatf("got kind %0d data %02h code %0d last %0d",
                                 token_if.payload.token_kind, token_if.payload.data_byte,
                                 token_if.payload.error_code, token_if.payload.last_result));
          end
        end
      end
      token_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (text_if.valid && text_if.ready) || (token_if.valid && token_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int target;
    text_if.valid = 1'b0;
    text_if.payload = '0;
    token_if.ready = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 59; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 59; end
        default: begin sender_idle_pct = 11; receiver_stall_pct = 11; end
      endcase
      if (phase == 0) begin
        send_bytes(text_bytes("{[-9e:,]}"));
        send_bytes('{CH_QUOTE, 8'hff, CH_BSLASH, CH_F, CH_BSLASH, CH_U});
        send_bytes('{8'h00});
        send_bytes(text_bytes("fals"));
        send_bytes(text_bytes("\""));
        send_bytes(text_bytes("5"));
        send_bytes(text_bytes("tx"));
      end
      target = bytes_sent + ITEMS_PER_PHASE;
      while (bytes_sent < target)
        random_message();
      // hold off the next phase until every expected token has drained
      while (bytes_in_flight != 0 || expected_tokens.size() != 0)
        @(posedge clk);
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- json_byte_tokenizer.f -----
+incdir+rtl
rtl/jbt_pkg.sv
rtl/jbt_chan.sv
rtl/jbt_lexer.sv
rtl/jbt_out_buf.sv
rtl/json_byte_tokenizer.sv
sim/json_byte_tokenizer_test.sv
